// ===== rtl/pets_pkg.sv =====
// ----------------------------------------------------------------------------
// pets_pkg
// types, codes and defaults shared by the pwm event table sequencer files
// ----------------------------------------------------------------------------
package pets_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 32;
	localparam int unsigned MASK_BYTES_DEF  = 4;
	localparam int unsigned SLOWDOWN_DEF    = 1;
	localparam int unsigned RESOLUTION_DEF  = 256;

	localparam int unsigned PORT_MASK_W = 32;
	localparam int unsigned TICK_W      = 16;
	localparam int unsigned CYCLE_W     = 8;

	typedef enum logic [1:0] {
		OP_EXPIRY      = 2'd0,
		OP_WRITE_ENTRY = 2'd1,
		OP_WRITE_ATTR  = 2'd2,
		OP_SWAP_REQ    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		SW_IDLE      = 2'd0,
		SW_REQUESTED = 2'd1,
		SW_INITIATED = 2'd2,
		SW_COPYING   = 2'd3
	} swap_state_t;

	typedef struct packed {
		op_t         operation;
		logic [4:0]  entry_index;
		logic [31:0] entry_mask;
		logic [15:0] entry_ticks;
		logic [5:0]  work_entry_count;
		logic [31:0] work_idle_bits;
	} req_item_t;

	typedef struct packed {
		logic [31:0] port_mask;
		logic [15:0] next_interval;
		logic        cycle_wrapped;
		logic [7:0]  cycle_count;
		swap_state_t swap_phase;
	} rsp_item_t;

	// what the control stage hands to the result stage for one expiry
	typedef struct packed {
		logic                     idle_path;
		logic                     fwd;
		logic                     wrapped;
		logic [PORT_MASK_W-1:0]   idle_mask;
		logic [CYCLE_W-1:0]       cycles;
		swap_state_t              swap;
	} event_info_t;

endpackage

// ===== rtl/pets_stream_if.sv =====
// ----------------------------------------------------------------------------
// pets_stream_if
// valid/ready channel carrying one item per transfer
// ----------------------------------------------------------------------------
interface pets_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pets_ram.sv =====
// ----------------------------------------------------------------------------
// pets_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pets_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/pets_ctrl.sv =====
// ----------------------------------------------------------------------------
// pets_ctrl
// input handshake, table attributes, swap state machine and read issue
// ----------------------------------------------------------------------------
module pets_ctrl
	import pets_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int unsigned MASK_W      = 32,
	parameter int unsigned IDXW        = 5,
	parameter int unsigned CNTW        = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	pets_stream_if.sink         req,
	// pending table write and copy read
	output logic                pend_we,
	output logic [IDXW-1:0]     pend_waddr,
	output logic [MASK_W+15:0]  pend_wdata,
	output logic                pend_re,
	output logic [IDXW-1:0]     pend_raddr,
	// active table copy write and event read
	output logic                act_we,
	output logic [IDXW-1:0]     act_waddr,
	output logic                act_re,
	output logic [IDXW-1:0]     act_raddr,
	// read stage towards the result stage
	output logic                s1_valid,
	output event_info_t         info,
	input  logic                advance
);

	swap_state_t         state_q, state_d;
	logic [CNTW-1:0]     act_count_q, act_count_d;
	logic [MASK_W-1:0]   act_idle_q, act_idle_d;
	logic [CNTW-1:0]     pend_count_q, pend_count_d;
	logic [MASK_W-1:0]   pend_idle_q, pend_idle_d;
	logic [IDXW-1:0]     event_idx_q, event_idx_d;
	logic [CNTW-1:0]     copy_idx_q, copy_idx_d;
	logic [CYCLE_W-1:0]  cycles_q, cycles_d;
	logic                s1_valid_q;
	event_info_t         info_s1, info_d;
	logic                copy_en_s1, copy_en;
	logic [IDXW-1:0]     copy_addr_s1;
	logic                accept;
	logic                expiry;
	logic [CNTW-1:0]     event_inc;
	logic [31:0]         count_sat;

	assign req.ready = !s1_valid_q;
	assign accept    = req.valid && req.ready;
	assign expiry    = accept && (req.data.operation == OP_EXPIRY);

	assign pend_we    = accept && (req.data.operation == OP_WRITE_ENTRY)
		&& (32'(req.data.entry_index) < 32'(TABLE_DEPTH));
	assign pend_waddr = IDXW'(req.data.entry_index);
	assign pend_wdata = {req.data.entry_mask[MASK_W-1:0], req.data.entry_ticks};
	assign pend_re    = expiry;
	assign pend_raddr = IDXW'(copy_idx_q);
	assign act_re     = expiry;
	assign act_raddr  = event_idx_q;
	// copy lands when the event leaves the read stage
	assign act_we     = advance && copy_en_s1;
	assign act_waddr  = copy_addr_s1;

	assign s1_valid = s1_valid_q;
	assign info     = info_s1;

	assign event_inc = CNTW'(event_idx_q) + CNTW'(1);
	assign count_sat = (32'(req.data.work_entry_count) > 32'(TABLE_DEPTH)) ?
		32'(TABLE_DEPTH) : 32'(req.data.work_entry_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SW_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		act_count_d  = act_count_q;
		act_idle_d   = act_idle_q;
		pend_count_d = pend_count_q;
		pend_idle_d  = pend_idle_q;
		event_idx_d  = event_idx_q;
		copy_idx_d   = copy_idx_q;
		cycles_d     = cycles_q;
		copy_en      = 1'b0;
		info_d.idle_path = (act_count_q == '0);
		info_d.fwd       = 1'b0;
		info_d.wrapped   = 1'b0;
		info_d.idle_mask = PORT_MASK_W'(act_idle_q);
		info_d.cycles    = cycles_q;
		info_d.swap      = state_q;
		if (accept) begin
			unique case (req.data.operation)
				OP_WRITE_ENTRY: begin
				end
				OP_WRITE_ATTR: begin
					pend_count_d = CNTW'(count_sat);
					pend_idle_d  = req.data.work_idle_bits[MASK_W-1:0];
				end
				OP_SWAP_REQ: begin
					if (state_q == SW_IDLE) begin
						state_d = SW_REQUESTED;
					end
				end
				OP_EXPIRY: begin
					if (act_count_q == '0) begin
						if (state_q == SW_INITIATED) begin
							state_d    = SW_IDLE;
							copy_idx_d = '0;
						end
						if (state_d == SW_REQUESTED) begin
							state_d     = SW_INITIATED;
							act_idle_d  = pend_idle_q;
							act_count_d = pend_count_q;
							event_idx_d = '0;
						end
					end else begin
						if (state_q == SW_INITIATED || state_q == SW_COPYING) begin
							copy_en    = 32'(copy_idx_q) < 32'(TABLE_DEPTH);
							copy_idx_d = copy_idx_q + CNTW'(1);
							state_d    = SW_COPYING;
						end
						// the entry being copied is also the one read: take it from pending
						info_d.fwd = copy_en && (32'(copy_idx_q) == 32'(event_idx_q));
						if (event_inc >= act_count_q) begin
							event_idx_d = '0;
							if (state_d == SW_COPYING) begin
								state_d    = SW_IDLE;
								copy_idx_d = '0;
							end
							if (state_d == SW_REQUESTED) begin
								state_d     = SW_INITIATED;
								act_idle_d  = pend_idle_q;
								act_count_d = pend_count_q;
							end
							cycles_d       = cycles_q + CYCLE_W'(1);
							info_d.wrapped = 1'b1;
						end else begin
							event_idx_d = IDXW'(event_inc);
						end
					end
					info_d.cycles = cycles_d;
					info_d.swap   = state_d;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_count_q  <= '0;
			act_idle_q   <= '0;
			pend_count_q <= '0;
			pend_idle_q  <= '0;
			event_idx_q  <= '0;
			copy_idx_q   <= '0;
			cycles_q     <= '0;
			s1_valid_q   <= 1'b0;
			copy_en_s1   <= 1'b0;
		end else begin
			act_count_q  <= act_count_d;
			act_idle_q   <= act_idle_d;
			pend_count_q <= pend_count_d;
			pend_idle_q  <= pend_idle_d;
			event_idx_q  <= event_idx_d;
			copy_idx_q   <= copy_idx_d;
			cycles_q     <= cycles_d;
			if (expiry) begin
				s1_valid_q <= 1'b1;
				copy_en_s1 <= copy_en;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
				copy_en_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (expiry) begin
			info_s1      <= info_d;
			copy_addr_s1 <= IDXW'(copy_idx_q);
		end
	end

endmodule

// ===== rtl/pets_out.sv =====
// ----------------------------------------------------------------------------
// pets_out
// resolves the table read into a result and holds it in the output register
// ----------------------------------------------------------------------------
module pets_out
	import pets_pkg::*;
#(
	parameter int unsigned MASK_W     = 32,
	parameter int unsigned SLOWDOWN   = SLOWDOWN_DEF,
	parameter int unsigned RESOLUTION = RESOLUTION_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s1_valid,
	input  event_info_t        info,
	input  logic [MASK_W+15:0] act_rdata,
	input  logic [MASK_W+15:0] pend_rdata,
	output logic               advance,
	pets_stream_if.source      rsp
);

	localparam logic [TICK_W-1:0] IDLE_INTERVAL = TICK_W'((RESOLUTION * SLOWDOWN) % 65536);

	logic               out_valid_q;
	rsp_item_t          out_data_q;
	rsp_item_t          result;
	logic [MASK_W+15:0] entry;
	logic [31:0]        scaled;

	assign advance = s1_valid && (!out_valid_q || rsp.ready);
	assign entry   = info.fwd ? pend_rdata : act_rdata;
	assign scaled  = 32'(entry[TICK_W-1:0]) * 32'(SLOWDOWN);

	always_comb begin
		result.port_mask     = info.idle_path ? info.idle_mask
			: PORT_MASK_W'(entry[MASK_W+15:TICK_W]);
		result.next_interval = info.idle_path ? IDLE_INTERVAL : scaled[TICK_W-1:0];
		result.cycle_wrapped = info.wrapped;
		result.cycle_count   = info.cycles;
		result.swap_phase    = info.swap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

endmodule

// ===== rtl/pwm_event_table_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// pwm_event_table_sequencer_unit
// double-buffered pwm event table sequencer, one result per timer expiry
// ----------------------------------------------------------------------------
// Entry writes, attribute writes and swap requests take effect at transfer.
// A timer expiry also passes the read stage: the active and pending tables are
// read in the transfer cycle, and once the result register can take it the
// registered ram data (or the pending entry being copied, when both name the
// same slot) is scaled and loaded into the result register, while the swap
// copy writes the active table. The input stays not-ready while an expiry sits
// in the read stage, so no request is taken until it moves on. Tables are not
// cleared at reset; an active entry no swap has copied reads as whatever the ram holds.
module pwm_event_table_sequencer_unit
	import pets_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int unsigned MASK_BYTES  = MASK_BYTES_DEF,
	parameter int unsigned SLOWDOWN    = SLOWDOWN_DEF,
	parameter int unsigned RESOLUTION  = RESOLUTION_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	pets_stream_if.sink   req,
	pets_stream_if.source rsp
);

	localparam int unsigned IDXW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNTW    = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned MASK_W  = (8 * MASK_BYTES > 32) ? 32 : 8 * MASK_BYTES;
	localparam int unsigned ENTRY_W = MASK_W + TICK_W;

	logic               pend_we, pend_re, act_we, act_re;
	logic [IDXW-1:0]    pend_waddr, pend_raddr, act_waddr, act_raddr;
	logic [ENTRY_W-1:0] pend_wdata, pend_rdata, act_rdata;
	logic               s1_valid, advance;
	event_info_t        info;

	pets_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MASK_W      (MASK_W),
		.IDXW        (IDXW),
		.CNTW        (CNTW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.pend_we    (pend_we),
		.pend_waddr (pend_waddr),
		.pend_wdata (pend_wdata),
		.pend_re    (pend_re),
		.pend_raddr (pend_raddr),
		.act_we     (act_we),
		.act_waddr  (act_waddr),
		.act_re     (act_re),
		.act_raddr  (act_raddr),
		.s1_valid   (s1_valid),
		.info       (info),
		.advance    (advance)
	);

	pets_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH),
		.AW    (IDXW)
	) u_pend_ram (
		.clk   (clk),
		.we    (pend_we),
		.waddr (pend_waddr),
		.wdata (pend_wdata),
		.re    (pend_re),
		.raddr (pend_raddr),
		.rdata (pend_rdata)
	);

	// the copy writes the pending entry just read straight into the active table
	pets_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH),
		.AW    (IDXW)
	) u_act_ram (
		.clk   (clk),
		.we    (act_we),
		.waddr (act_waddr),
		.wdata (pend_rdata),
		.re    (act_re),
		.raddr (act_raddr),
		.rdata (act_rdata)
	);

	pets_out #(
		.MASK_W     (MASK_W),
		.SLOWDOWN   (SLOWDOWN),
		.RESOLUTION (RESOLUTION)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1_valid   (s1_valid),
		.info       (info),
		.act_rdata  (act_rdata),
		.pend_rdata (pend_rdata),
		.advance    (advance),
		.rsp        (rsp)
	);

endmodule

// ===== rtl/pets_checker.sv =====
// ----------------------------------------------------------------------------
// pets_checker
// port-level checks for the pwm event table sequencer, bound to the top level
// ----------------------------------------------------------------------------
module pets_checker
	import pets_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input op_t       req_op,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rsp_item_t rsp_data
);

	logic expiry_xfer;

	assign expiry_xfer = req_valid && req_ready && (req_op == OP_EXPIRY);

	// a stalled result holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// an expiry occupies the read stage for the following cycle
	a_expiry_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		expiry_xfer |=> !req_ready)
		else $error("input ready while expiry in read stage");

	// a result rising from idle comes from an expiry that passed the read stage unstalled
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(expiry_xfer, 2))
		else $error("result without a matching expiry");

	// a cycle end never leaves a swap requested or still copying
	a_wrap_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.cycle_wrapped |->
			rsp_data.swap_phase == SW_IDLE || rsp_data.swap_phase == SW_INITIATED)
		else $error("swap phase inconsistent with cycle end");

endmodule

bind pwm_event_table_sequencer_unit pets_checker u_pets_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_op    (req.data.operation),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

// ===== tb/pwm_event_table_sequencer_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwm_event_table_sequencer_unit_tb
// drives table writes, attribute writes, swap requests and timer expiries
// through the request channel with random gaps, and checks every result
// against a cycle-free model of the double-buffered event table
// ----------------------------------------------------------------------------
module pwm_event_table_sequencer_unit_tb;
	import pets_pkg::*;

	localparam logic [31:0] MASK_KEEP = (MASK_BYTES_DEF >= 4) ? 32'hFFFF_FFFF :
		32'((64'd1 << (8 * MASK_BYTES_DEF)) - 64'd1);
	localparam int unsigned STIM_ITEMS = 1050;
	localparam int unsigned IDX_W      = (TABLE_DEPTH_DEF > 1) ? $clog2(TABLE_DEPTH_DEF) : 1;

	typedef struct {
		req_item_t item;
		bit        hold;
	} stim_t;

	logic clk;
	logic arst_n;

	pets_stream_if #(.T(req_item_t)) req_if ();
	pets_stream_if #(.T(rsp_item_t)) rsp_if ();

	pwm_event_table_sequencer_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// sequencer model state
	logic [31:0]  act_mask [TABLE_DEPTH_DEF];
	logic [15:0]  act_ticks [TABLE_DEPTH_DEF];
	logic [31:0]  pend_mask [TABLE_DEPTH_DEF];
	logic [15:0]  pend_ticks [TABLE_DEPTH_DEF];
	logic [31:0]  act_idle;
	logic [5:0]   act_count;
	logic [31:0]  pend_idle;
	logic [5:0]   pend_count;
	logic [5:0]   ev_idx;
	logic [5:0]   cp_idx;
	logic [7:0]   cycles;
	swap_state_t  sw;

	rsp_item_t    expected_events [$];
	stim_t        stim_q [$];
	bit           written [TABLE_DEPTH_DEF];

	int           n_offered;
	int           n_taken;
	int           total_items;
	int           errors;
	int           results_seen;
	int           cyc;
	rsp_item_t    want;
	rsp_item_t    got;

	wire calm = (cyc >= 900) && (cyc < 1500);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------ model

	task automatic take_swap();
		if (sw == SW_REQUESTED) begin
			sw        = SW_INITIATED;
			act_idle  = pend_idle;
			act_count = pend_count;
			ev_idx    = '0;
		end
	endtask

	task automatic sequence_item(input req_item_t it);
		rsp_item_t r;
		r = '0;
		unique case (it.operation)
			OP_WRITE_ENTRY: begin
				if (it.entry_index < TABLE_DEPTH_DEF) begin
					pend_mask[IDX_W'(it.entry_index)]  = it.entry_mask & MASK_KEEP;
					pend_ticks[IDX_W'(it.entry_index)] = it.entry_ticks;
				end
			end
			OP_WRITE_ATTR: begin
				pend_count = (it.work_entry_count > TABLE_DEPTH_DEF) ?
					6'(TABLE_DEPTH_DEF) : it.work_entry_count;
				pend_idle  = it.work_idle_bits & MASK_KEEP;
			end
			OP_SWAP_REQ: begin
				if (sw == SW_IDLE)
					sw = SW_REQUESTED;
			end
			default: begin
				r.cycle_wrapped = 1'b0;
				if (act_count == 0) begin
					// idle path: no cycle ends, a zero-count swap falls back to idle and a requested one is taken
					r.port_mask     = act_idle;
					r.next_interval = 16'(RESOLUTION_DEF * SLOWDOWN_DEF);
					if (sw == SW_INITIATED) begin
						sw     = SW_IDLE;
						cp_idx = '0;
					end
					take_swap();
				end else begin
					if (sw == SW_INITIATED || sw == SW_COPYING) begin
						if (cp_idx < TABLE_DEPTH_DEF) begin
							act_mask[IDX_W'(cp_idx)]  = pend_mask[IDX_W'(cp_idx)];
							act_ticks[IDX_W'(cp_idx)] = pend_ticks[IDX_W'(cp_idx)];
						end
						cp_idx = cp_idx + 6'd1;
						sw     = SW_COPYING;
					end
					if (ev_idx >= TABLE_DEPTH_DEF)
						ev_idx = '0;
					r.port_mask     = act_mask[IDX_W'(ev_idx)];
					r.next_interval = 16'(act_ticks[IDX_W'(ev_idx)] * SLOWDOWN_DEF);
					ev_idx = ev_idx + 6'd1;
					if (ev_idx >= act_count) begin
						ev_idx = '0;
						if (sw == SW_COPYING) begin
							sw     = SW_IDLE;
							cp_idx = '0;
						end
						take_swap();
						cycles          = cycles + 8'd1;
						r.cycle_wrapped = 1'b1;
					end
				end
				r.cycle_count = cycles;
				r.swap_phase  = sw;
				expected_events.push_back(r);
			end
		endcase
	endtask

	// -------------------------------------------------------------- stimulus

	function automatic req_item_t random_item(op_t op);
		req_item_t it;
		it.operation        = op;
		it.entry_index      = 5'($urandom_range(0, 31));
		it.entry_mask       = $urandom;
		it.entry_ticks      = 16'($urandom_range(0, 65535));
		it.work_entry_count = 6'($urandom_range(0, 63));
		it.work_idle_bits   = $urandom;
		return it;
	endfunction

	function automatic void queue_item(req_item_t it, bit hold);
		stim_t s;
		s.item = it;
		s.hold = hold;
		stim_q.push_back(s);
	endfunction

	function automatic void add_entry(int idx, logic [31:0] mask, logic [15:0] ticks);
		req_item_t it;
		it             = random_item(OP_WRITE_ENTRY);
		it.entry_index = 5'(idx);
		it.entry_mask  = mask;
		it.entry_ticks = ticks;
		written[IDX_W'(idx)] = 1'b1;
		queue_item(it, 1'b0);
	endfunction

	// pending entries below the count are always written first, so a swap
	// never copies an entry that holds nothing defined
	function automatic void add_attr(int cnt, logic [31:0] idle);
		req_item_t it;
		int lim;
		lim = (cnt > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : cnt;
		for (int i = 0; i < lim; i++)
			if (!written[IDX_W'(i)])
				add_entry(i, $urandom, 16'($urandom_range(0, 65535)));
		it                  = random_item(OP_WRITE_ATTR);
		it.work_entry_count = 6'(cnt);
		it.work_idle_bits   = idle;
		queue_item(it, 1'b0);
	endfunction

	function automatic void add_expiry();
		queue_item(random_item(OP_EXPIRY), 1'b0);
	endfunction

	function automatic void add_swap(bit hold);
		queue_item(random_item(OP_SWAP_REQ), hold);
	endfunction

	function automatic void add_noise();
		req_item_t it;
		it = random_item(op_t'($urandom_range(0, 3)));
		unique case (it.operation)
			OP_WRITE_ENTRY: add_entry(it.entry_index, it.entry_mask, it.entry_ticks);
			OP_WRITE_ATTR:  add_attr(it.work_entry_count, it.work_idle_bits);
			default:        queue_item(it, 1'b0);
		endcase
	endfunction

	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 0;
		else if (r < 50)
			return $urandom_range(1, 3);
		else if (r < 80)
			return $urandom_range(4, 8);
		else if (r < 90)
			return $urandom_range(9, 31);
		else if (r < 95)
			return TABLE_DEPTH_DEF;
		return $urandom_range(TABLE_DEPTH_DEF + 1, 63);
	endfunction

	task automatic build_stimulus();
		int cnt;
		int eff;
		int n;
		// expiry straight after reset, then a zero-count swap
		add_expiry();
		add_attr(0, 32'hFFFF_FFFF);
		add_swap(1'b0);
		add_swap(1'b0);
		add_expiry();
		add_expiry();
		// three-entry table with extreme contents
		add_entry(0, 32'hFFFF_FFFF, 16'hFFFF);
		add_entry(1, 32'h0000_0000, 16'h0000);
		add_entry(2, 32'h8000_0001, 16'h0001);
		add_attr(3, 32'h0000_0000);
		add_swap(1'b0);
		add_expiry();
		add_expiry();
		// request during copying is dropped, pending write lands before its copy
		add_swap(1'b0);
		add_entry(1, 32'h5A5A_5A5A, 16'h7FFF);
		add_expiry();
		add_expiry();
		add_expiry();
		// oversized count saturates to the table depth
		add_attr(63, 32'hAAAA_AAAA);
		add_swap(1'b1);
		add_expiry();
		add_expiry();
		add_expiry();

		// single-entry table run long enough to roll the cycle counter over
		add_attr(1, $urandom);
		repeat (64) add_expiry();
		add_swap(1'b1);
		repeat (300) add_expiry();

		while (stim_q.size() < STIM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				add_noise();
			end else begin
				repeat ($urandom_range(0, 4))
					add_entry($urandom_range(0, 31), $urandom, 16'($urandom_range(0, 65535)));
				cnt = pick_count();
				eff = (cnt > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : cnt;
				add_attr(cnt, $urandom);
				add_swap($urandom_range(0, 19) == 0);
				n = $urandom_range(1, 2 * eff + 3);
				if (n > 60)
					n = 60;
				repeat (n) begin
					if ($urandom_range(0, 15) == 0)
						add_noise();
					add_expiry();
				end
			end
		end
		total_items = stim_q.size();
	endtask

	// ---------------------------------------------------------------- driver

	always @(negedge clk) begin
		rsp_if.ready <= calm || ($urandom_range(0, 99) >= 36);
		if (arst_n && !(req_if.valid && n_taken != n_offered)) begin
			if (stim_q.size() != 0 && (calm || $urandom_range(0, 99) >= 36) &&
			    !(stim_q[0].hold && expected_events.size() != 0)) begin
				req_if.data  <= stim_q[0].item;
				req_if.valid <= 1'b1;
				stim_q.pop_front();
				n_offered++;
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// --------------------------------------------------------------- monitor

	always @(posedge clk) begin
		if (arst_n) begin
			cyc++;
			// results first: none can come from an item taken at this same edge
			if (rsp_if.valid && rsp_if.ready) begin
				got = rsp_if.data;
				results_seen++;
				if (expected_events.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("result %0d with nothing expected: mask %h interval %h",
							results_seen, got.port_mask, got.next_interval);
				end else begin
					want = expected_events.pop_front();
					if (got.port_mask !== want.port_mask ||
					    got.next_interval !== want.next_interval ||
					    got.cycle_wrapped !== want.cycle_wrapped ||
					    got.cycle_count !== want.cycle_count ||
					    got.swap_phase !== want.swap_phase) begin
						errors++;
						if (errors <= 10)
							$display("result %0d: expected %h %h %b %0d %0d, got %h %h %b %0d %0d",
								results_seen,
								want.port_mask, want.next_interval, want.cycle_wrapped,
								want.cycle_count, want.swap_phase,
								got.port_mask, got.next_interval, got.cycle_wrapped,
								got.cycle_count, got.swap_phase);
					end
				end
			end
			if (req_if.valid && req_if.ready) begin
				sequence_item(req_if.data);
				n_taken++;
			end
		end
	end

	// ------------------------------------------------------------------ main

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		rsp_if.ready = 1'b0;
		n_offered    = 0;
		n_taken      = 0;
		errors       = 0;
		results_seen = 0;
		cyc          = 0;
		act_idle     = '0;
		act_count    = '0;
		pend_idle    = '0;
		pend_count   = '0;
		ev_idx       = '0;
		cp_idx       = '0;
		cycles       = '0;
		sw           = SW_IDLE;
		for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
			act_mask[IDX_W'(i)]   = '0;
			act_ticks[IDX_W'(i)]  = '0;
			pend_mask[IDX_W'(i)]  = '0;
			pend_ticks[IDX_W'(i)] = '0;
			written[IDX_W'(i)]    = 1'b0;
		end
		build_stimulus();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (n_taken == total_items);
		wait (expected_events.size() == 0);
		repeat (10) @(posedge clk);
		if (errors == 0 && expected_events.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/pets_pkg.sv
rtl/pets_stream_if.sv
rtl/pets_ram.sv
rtl/pets_ctrl.sv
rtl/pets_out.sv
rtl/pwm_event_table_sequencer_unit.sv
rtl/pets_checker.sv
tb/pwm_event_table_sequencer_unit_tb.sv
